// ===== hw/rtl/sprite_layer_projection_assert.svh =====
// ----------------------------------------------------------------------------
// Sprite layer projection assertion macros
// Concurrent assertion wrappers clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPRITE_LAYER_PROJECTION_ASSERT_SVH
`define SPRITE_LAYER_PROJECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define SLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define SLP_ASSERT(lbl, prop, msg)
`define SLP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/slp_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite layer projection package
// Register map, fixed-point widths and the divider pipeline word.
// ----------------------------------------------------------------------------
package slp_pkg;

	localparam int MAX_SLICES = 64;

	typedef enum logic [2:0] {
		CFG_SIN_YAW       = 3'd0,
		CFG_SIN_PITCH     = 3'd1,
		CFG_COS_PITCH     = 3'd2,
		CFG_ZOOM          = 3'd3,
		CFG_LAYER_LIFT    = 3'd4,
		CFG_DEPTH_STEP    = 3'd5,
		CFG_VIEW_DISTANCE = 3'd6,
		CFG_SLICE_COUNT   = 3'd7
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int CNT_W      = 7;

	localparam logic signed [15:0] RST_SIN_YAW   = 16'sd0;
	localparam logic signed [15:0] RST_SIN_PITCH = 16'sd0;
	localparam logic signed [15:0] RST_COS_PITCH = 16'sd16384;
	localparam logic [15:0]        RST_ZOOM      = 16'd256;
	localparam logic signed [15:0] RST_LIFT      = 16'sd0;
	localparam logic [15:0]        RST_DEPTH     = 16'd256;
	localparam logic [19:0]        RST_VIEW_DIST = 20'd51200;
	localparam logic [CNT_W-1:0]   RST_SLICES    = 7'd1;
	localparam logic [CNT_W-1:0]   SLICE_MAX     = CNT_W'(MAX_SLICES);

	// datapath widths
	localparam int K_W     = 8;   // 2*j - (n-1)
	localparam int WZ_W    = 26;  // size * zoom
	localparam int JL_W    = 23;  // j * lift
	localparam int CZ_W    = 33;  // cos * zoom
	localparam int LIFT_W  = 56;  // j * lift * cos * zoom, Q30
	localparam int Z_W     = 25;  // z in Q9
	localparam int D9_W    = 21;  // distance in Q9
	localparam int DEN_SW  = 26;  // signed denominator
	localparam int DEN_W   = 24;  // denominator magnitude
	localparam int P_W     = 41;  // z * sin
	localparam int PP_SH   = 20;  // split point of z * sin
	localparam int PPL_W   = PP_SH + D9_W;
	localparam int PPH_W   = (P_W - PP_SH) + D9_W + 1;
	localparam int NUM_W   = 62;  // z * sin * d
	localparam int NMAG_W  = 61;
	localparam int BASE_W  = 57;  // Q30 position sums
	localparam int SH_W    = 55;  // signed perspective shift
	localparam int POS_W   = 16;
	localparam int RND_W   = BASE_W - 30;

	// quotient floor(|num| * 2^FRAC_SH / |den|), limited below 2^QUO_W
	localparam int FRAC_SH    = 7;
	localparam int QUO_W      = 54;
	localparam int RSH        = QUO_W - FRAC_SH;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = QUO_W / DIV_STEPS;

	localparam int PRE_STG  = 6;
	localparam int POST_STG = 3;
	localparam int NSTG     = PRE_STG + DIV_STAGES + POST_STG;

	localparam logic [QUO_W-1:0] QUO_SAT = QUO_W'(1) << (QUO_W - 1);
	localparam logic [QUO_W-1:0] QUO_THR = QUO_SAT + QUO_W'(128);

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic [QUO_W-1:0] divd;
		logic             presat;
		logic             neg;
		logic             zr;
	} slp_lane_t;

	typedef struct packed {
		slp_lane_t                 x;
		slp_lane_t                 y;
		logic [DEN_W-1:0]          den_mag;
		logic signed [BASE_W-1:0]  bx;
		logic signed [BASE_W-1:0]  by;
		logic                      sat_den;
	} slp_div_t;

endpackage

// ===== hw/rtl/sprite_layer_projection.sv =====
// ----------------------------------------------------------------------------
// Sprite layer projection
// Screen position of one sprite-stack slice with perspective, yaw, pitch,
// layer lift and zoom; rounded and clamped to 16 bits.
// ----------------------------------------------------------------------------
// Takes one slice word per clock while the pipeline is not stalled and returns
// one position word per slice, in order. The core of the pipeline is the
// perspective divide: a 27-stage pipeline that resolves two quotient bits per
// stage for x and y against the shared z denominator. Six stages of multiplies,
// sums and divider setup feed it and three stages add, round and clamp. Any
// stage that is empty lets the words behind it advance, so input is taken while
// a finished word waits at the output if any stage is empty. Configuration
// writes are taken every cycle and must only happen while no slice is in flight.
`include "sprite_layer_projection_assert.svh"

module sprite_layer_projection import slp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,

	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [5:0]             slice_index,
	input  logic [9:0]             sprite_width,
	input  logic [9:0]             sprite_height,
	input  logic signed [15:0]     anchor_x,
	input  logic signed [15:0]     anchor_y,

	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [15:0]     screen_x,
	output logic signed [15:0]     screen_y,
	output logic                   clamped
);

	typedef struct packed {
		logic signed [POS_W-1:0] v;
		logic                    sat;
	} slp_pos_t;

	// ------------------------------------------------------------------ config
	logic signed [15:0] sin_yaw_q, sin_pitch_q, cos_pitch_q, layer_lift_q;
	logic [15:0]        zoom_q, depth_step_q;
	logic [19:0]        view_dist_q;
	logic [CNT_W-1:0]   slice_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sin_yaw_q     <= RST_SIN_YAW;
			sin_pitch_q   <= RST_SIN_PITCH;
			cos_pitch_q   <= RST_COS_PITCH;
			zoom_q        <= RST_ZOOM;
			layer_lift_q  <= RST_LIFT;
			depth_step_q  <= RST_DEPTH;
			view_dist_q   <= RST_VIEW_DIST;
			slice_count_q <= RST_SLICES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SIN_YAW:       sin_yaw_q     <= cfg_data[15:0];
				CFG_SIN_PITCH:     sin_pitch_q   <= cfg_data[15:0];
				CFG_COS_PITCH:     cos_pitch_q   <= cfg_data[15:0];
				CFG_ZOOM:          zoom_q        <= cfg_data[15:0];
				CFG_LAYER_LIFT:    layer_lift_q  <= cfg_data[15:0];
				CFG_DEPTH_STEP:    depth_step_q  <= cfg_data[15:0];
				CFG_VIEW_DISTANCE: view_dist_q   <= cfg_data[19:0];
				CFG_SLICE_COUNT:   slice_count_q <= cfg_data[CNT_W-1:0];
			endcase
		end
	end

	logic [D9_W-1:0] d9;
	assign d9 = {view_dist_q, 1'b0};

	// --------------------------------------------------------------- handshake
	logic [NSTG-1:0] vld;
	logic [NSTG-1:0] en;
	logic            in_fire, out_fire;

	for (genvar k = 0; k < NSTG; k++) begin : g_en
		assign en[k] = out_ready | ~(&vld[NSTG-1:k]);
	end

	assign in_ready  = en[0];
	assign out_valid = vld[NSTG-1];
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			for (int k = 0; k < NSTG; k++) begin
				if (en[k]) begin
					vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	// ----------------------------------------------------------------- stage 1
	logic [CNT_W-1:0]         n_c;
	logic signed [K_W-1:0]    k_s1;
	logic [WZ_W-1:0]          wz_s1, hz_s1;
	logic signed [JL_W-1:0]   jl_s1;
	logic signed [CZ_W-1:0]   cz_s1;
	logic signed [15:0]       ax_s1, ay_s1;

	always_comb begin
		if (slice_count_q == '0) begin
			n_c = CNT_W'(1);
		end else if (slice_count_q > SLICE_MAX) begin
			n_c = SLICE_MAX;
		end else begin
			n_c = slice_count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			k_s1  <= $signed({1'b0, slice_index, 1'b0}) - $signed({1'b0, CNT_W'(n_c - 1'b1)});
			wz_s1 <= WZ_W'(sprite_width) * WZ_W'(zoom_q);
			hz_s1 <= WZ_W'(sprite_height) * WZ_W'(zoom_q);
			jl_s1 <= $signed({1'b0, slice_index}) * layer_lift_q;
			cz_s1 <= cos_pitch_q * $signed({1'b0, zoom_q});
			ax_s1 <= anchor_x;
			ay_s1 <= anchor_y;
		end
	end

	// ----------------------------------------------------------------- stage 2
	logic signed [Z_W-1:0]    z9_s2;
	logic signed [LIFT_W-1:0] lift_s2;
	logic [WZ_W-1:0]          wz_s2, hz_s2;
	logic signed [15:0]       ax_s2, ay_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			z9_s2   <= k_s1 * $signed({1'b0, depth_step_q});
			lift_s2 <= jl_s1 * cz_s1;
			wz_s2   <= wz_s1;
			hz_s2   <= hz_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
		end
	end

	// ----------------------------------------------------------------- stage 3
	logic signed [P_W-1:0]    px_s3, py_s3;
	logic signed [DEN_SW-1:0] den_s3;
	logic signed [BASE_W-1:0] bx_s3, by_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			px_s3  <= z9_s2 * sin_yaw_q;
			py_s3  <= z9_s2 * sin_pitch_q;
			den_s3 <= DEN_SW'($signed({1'b0, d9})) - DEN_SW'(z9_s2);
			bx_s3  <= (BASE_W'(ax_s2) <<< 26) - $signed(BASE_W'(wz_s2) << 21);
			by_s3  <= (BASE_W'(ay_s2) <<< 26) - $signed(BASE_W'(hz_s2) << 21)
				- BASE_W'(lift_s2);
		end
	end

	// ------------------------------------------------- stage 4: partial products
	logic [PPL_W-1:0]         ppl_x_s4, ppl_y_s4;
	logic signed [PPH_W-1:0]  pph_x_s4, pph_y_s4;
	logic                     pxn_s4, pyn_s4, pxz_s4, pyz_s4;
	logic signed [DEN_SW-1:0] den_s4;
	logic signed [BASE_W-1:0] bx_s4, by_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ppl_x_s4 <= PPL_W'(px_s3[PP_SH-1:0]) * PPL_W'(d9);
			ppl_y_s4 <= PPL_W'(py_s3[PP_SH-1:0]) * PPL_W'(d9);
			pph_x_s4 <= $signed(px_s3[P_W-1:PP_SH]) * $signed({1'b0, d9});
			pph_y_s4 <= $signed(py_s3[P_W-1:PP_SH]) * $signed({1'b0, d9});
			pxn_s4   <= px_s3[P_W-1];
			pyn_s4   <= py_s3[P_W-1];
			pxz_s4   <= (px_s3 == '0);
			pyz_s4   <= (py_s3 == '0);
			den_s4   <= den_s3;
			bx_s4    <= bx_s3;
			by_s4    <= by_s3;
		end
	end

	// ------------------------------------------------------------------ stage 5
	logic signed [NUM_W-1:0]  num_x_s5, num_y_s5;
	logic                     pxn_s5, pyn_s5, pxz_s5, pyz_s5;
	logic                     den_neg_s5, den_zero_s5;
	logic [DEN_W-1:0]         den_mag_s5;
	logic signed [BASE_W-1:0] bx_s5, by_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			num_x_s5    <= (NUM_W'(pph_x_s4) <<< PP_SH) + $signed(NUM_W'(ppl_x_s4));
			num_y_s5    <= (NUM_W'(pph_y_s4) <<< PP_SH) + $signed(NUM_W'(ppl_y_s4));
			pxn_s5      <= pxn_s4;
			pyn_s5      <= pyn_s4;
			pxz_s5      <= pxz_s4;
			pyz_s5      <= pyz_s4;
			den_neg_s5  <= den_s4[DEN_SW-1];
			den_zero_s5 <= (den_s4 == '0);
			den_mag_s5  <= den_s4[DEN_SW-1] ? DEN_W'(-den_s4) : DEN_W'(den_s4);
			bx_s5       <= bx_s4;
			by_s5       <= by_s4;
		end
	end

	// ------------------------------------------------- stage 6: divider setup
	function automatic slp_lane_t lane_init(
		input logic signed [NUM_W-1:0] num,
		input logic                    p_neg,
		input logic                    p_zero,
		input logic                    d_neg,
		input logic                    d_zero,
		input logic [DEN_W-1:0]        dm
	);
		logic [NUM_W-1:0]  mag_w;
		logic [NMAG_W-1:0] nmag;
		slp_lane_t         l;
		mag_w    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		nmag     = mag_w[NMAG_W-1:0];
		l.rem    = DEN_W'(nmag[NMAG_W-1:RSH]);
		l.quo    = '0;
		l.divd   = {nmag[RSH-1:0], {FRAC_SH{1'b0}}};
		l.presat = d_zero || (DEN_W'(nmag[NMAG_W-1:RSH]) >= dm);
		l.neg    = d_zero ? p_neg : (num[NUM_W-1] ^ d_neg);
		l.zr     = d_zero && p_zero;
		return l;
	endfunction

	slp_div_t div_s6;
	slp_div_t div_c [DIV_STAGES+1];

	always_ff @(posedge clk) begin
		if (en[PRE_STG-1]) begin
			div_s6.x       <= lane_init(num_x_s5, pxn_s5, pxz_s5, den_neg_s5, den_zero_s5,
				den_mag_s5);
			div_s6.y       <= lane_init(num_y_s5, pyn_s5, pyz_s5, den_neg_s5, den_zero_s5,
				den_mag_s5);
			div_s6.den_mag <= den_mag_s5;
			div_s6.bx      <= bx_s5;
			div_s6.by      <= by_s5;
			div_s6.sat_den <= den_zero_s5 && !(pxz_s5 && pyz_s5);
		end
	end

	assign div_c[0] = div_s6;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		slp_div_stage u_div (
			.clk   (clk),
			.en    (en[PRE_STG+i]),
			.d_in  (div_c[i]),
			.d_out (div_c[i+1])
		);
	end

	// ------------------------------------------------ stage 34: position sums
	function automatic logic signed [SH_W-1:0] persp_shift(input slp_lane_t l);
		logic [QUO_W-1:0]        mag;
		logic signed [SH_W-1:0]  sv;
		mag = (l.presat || l.quo >= QUO_THR) ? QUO_SAT : l.quo;
		sv  = $signed(SH_W'(mag));
		if (l.zr) begin
			sv = '0;
		end else if (l.neg) begin
			sv = -sv;
		end
		return sv;
	endfunction

	slp_div_t                 div_o;
	logic signed [BASE_W-1:0] fx_s34, fy_s34;
	logic                     sat_den_s34;

	assign div_o = div_c[DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en[PRE_STG+DIV_STAGES]) begin
			fx_s34      <= div_o.bx + BASE_W'(persp_shift(div_o.x));
			fy_s34      <= div_o.by + BASE_W'(persp_shift(div_o.y));
			sat_den_s34 <= div_o.sat_den;
		end
	end

	// -------------------------------------------------------- stage 35: round
	logic [BASE_W-1:0] ax_mag, ay_mag;
	logic [RND_W-1:0]  rx_s35, ry_s35;
	logic              nx_s35, ny_s35, sat_den_s35;

	always_comb begin
		ax_mag = (fx_s34[BASE_W-1] ? BASE_W'(-fx_s34) : BASE_W'(fx_s34)) + BASE_W'(1 << 29);
		ay_mag = (fy_s34[BASE_W-1] ? BASE_W'(-fy_s34) : BASE_W'(fy_s34)) + BASE_W'(1 << 29);
	end

	always_ff @(posedge clk) begin
		if (en[NSTG-2]) begin
			rx_s35      <= ax_mag[BASE_W-1:30];
			ry_s35      <= ay_mag[BASE_W-1:30];
			nx_s35      <= fx_s34[BASE_W-1];
			ny_s35      <= fy_s34[BASE_W-1];
			sat_den_s35 <= sat_den_s34;
		end
	end

	// ------------------------------------------------- stage 36: clamp, output
	function automatic slp_pos_t clamp16(input logic neg, input logic [RND_W-1:0] p);
		slp_pos_t r;
		r.sat = 1'b0;
		if (!neg) begin
			if (p > RND_W'(32767)) begin
				r.v   = 16'sh7fff;
				r.sat = 1'b1;
			end else begin
				r.v = POS_W'(p);
			end
		end else begin
			if (p > RND_W'(32768)) begin
				r.v   = -16'sh8000;
				r.sat = 1'b1;
			end else begin
				r.v = POS_W'(-p);
			end
		end
		return r;
	endfunction

	slp_pos_t           cx, cy;
	logic signed [15:0] sx_s36, sy_s36;
	logic               sat_s36;

	always_comb begin
		cx = clamp16(nx_s35, rx_s35);
		cy = clamp16(ny_s35, ry_s35);
	end

	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			sx_s36  <= cx.v;
			sy_s36  <= cy.v;
			sat_s36 <= sat_den_s35 | cx.sat | cy.sat;
		end
	end

	assign screen_x = sx_s36;
	assign screen_y = sy_s36;
	assign clamped  = sat_s36;

	// -------------------------------------------------------------- assertions
	`SLP_ASSERT(a_ready_when_drained, !out_valid |-> in_ready, "input stalled with output empty")
	`SLP_ASSERT_NEXT(a_word_count, 1'b1, $countones(vld) == $past($countones(vld)) + $past(in_fire) - $past(out_fire), "word lost or duplicated in pipeline")

	for (genvar i = 0; i <= DIV_STAGES; i++) begin : g_chk
		`SLP_ASSERT(a_rem_bound, vld[PRE_STG-1+i] |-> ((div_c[i].x.presat || div_c[i].x.rem < div_c[i].den_mag) && (div_c[i].y.presat || div_c[i].y.rem < div_c[i].den_mag)), "divider remainder out of range")
	end

endmodule

// ===== hw/rtl/slp_div_stage.sv =====
// ----------------------------------------------------------------------------
// Sprite layer projection divider stage
// Two restoring quotient bits per lane, x and y lanes share the divisor.
// ----------------------------------------------------------------------------
module slp_div_stage import slp_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  slp_div_t d_in,
	output slp_div_t d_out
);

	function automatic slp_lane_t lane_step(input slp_lane_t li, input logic [DEN_W-1:0] dm);
		slp_lane_t    lo;
		logic [DEN_W:0] r2;
		lo = li;
		for (int i = 0; i < DIV_STEPS; i++) begin
			r2 = {lo.rem, lo.divd[QUO_W-1]};
			lo.divd = {lo.divd[QUO_W-2:0], 1'b0};
			if (r2 >= {1'b0, dm}) begin
				r2 = r2 - {1'b0, dm};
				lo.quo = {lo.quo[QUO_W-2:0], 1'b1};
			end else begin
				lo.quo = {lo.quo[QUO_W-2:0], 1'b0};
			end
			lo.rem = r2[DEN_W-1:0];
		end
		return lo;
	endfunction

	slp_div_t nxt;

	always_comb begin
		nxt = d_in;
		nxt.x = lane_step(d_in.x, d_in.den_mag);
		nxt.y = lane_step(d_in.y, d_in.den_mag);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule
